[sv/pgp_pkg.sv]
// Shared types and constants of the breath-and-tilt pointer controller.
// Item structs, register indexes, click codes, controller command bundle.
// No dependencies.
package pgp_pkg;

	localparam int ADC_BITS = 10;

	typedef enum logic [2:0] {
		REG_DAMPING  = 3'd0,
		REG_GAIN     = 3'd1,
		REG_PRESSURE = 3'd2,
		REG_GAP      = 3'd3,
		REG_HOLD     = 3'd4
	} pgp_reg_t;

	localparam logic [1:0] CLICK_NONE  = 2'd0;
	localparam logic [1:0] CLICK_LEFT  = 2'd1;
	localparam logic [1:0] CLICK_RIGHT = 2'd2;

	localparam logic [15:0] DAMPING_RESET  = 16'd9830;
	localparam logic [15:0] GAIN_RESET     = 16'd512;
	localparam logic [ADC_BITS-1:0] PRESSURE_RESET = ADC_BITS'(600);
	localparam logic [15:0] GAP_RESET      = 16'd400;
	localparam logic [15:0] HOLD_RESET     = 16'd1200;

	typedef struct packed {
		logic signed [15:0]    rate_horizontal;
		logic signed [15:0]    rate_vertical;
		logic [ADC_BITS-1:0]   pressure;
		logic [31:0]           now_ms;
	} pgp_in_t;

	typedef struct packed {
		logic signed [7:0] move_x;
		logic signed [7:0] move_y;
		logic [1:0]        click;
		logic              home_request;
	} pgp_out_t;

	// one step of the sequencer per bit; at most one bit set
	typedef struct packed {
		logic accept;
		logic mul_new;
		logic mul_old;
		logic sum;
		logic gain;
		logic scale;
		logic load;
	} pgp_cmd_t;

endpackage

[sv/pgp_ctrl.sv]
// Sequencer of the pointer controller: walks one item through the datapath steps.
// Depends on pgp_pkg.
module pgp_ctrl import pgp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     out_valid,
	input  logic     out_stall,
	output logic     in_stall,
	output pgp_cmd_t cmd
);

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_MUL_NEW = 7'b0000010,
		S_MUL_OLD = 7'b0000100,
		S_SUM     = 7'b0001000,
		S_GAIN    = 7'b0010000,
		S_SCALE   = 7'b0100000,
		S_DONE    = 7'b1000000
	} pgp_state_t;

	pgp_state_t state_q, state_d;
	logic       out_free;

	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_MUL_NEW;
				end
			end
			S_MUL_NEW: begin
				cmd.mul_new = 1'b1;
				state_d     = S_MUL_OLD;
			end
			S_MUL_OLD: begin
				cmd.mul_old = 1'b1;
				state_d     = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_GAIN;
			end
			S_GAIN: begin
				cmd.gain = 1'b1;
				state_d  = S_SCALE;
			end
			S_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = S_DONE;
			end
			S_DONE: begin
				// hold until the output register can take the result
				if (out_free) begin
					cmd.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[sv/pgp_lane.sv]
// One motion axis: exponential average and saturated pointer step on a shared multiplier.
// Depends on pgp_pkg.
module pgp_lane import pgp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  pgp_cmd_t           cmd,
	input  logic signed [15:0] rate,
	input  logic [15:0]        damping,
	input  logic [15:0]        gain,
	input  logic               negate,
	output logic signed [7:0]  move
);

	logic signed [23:0] avg_q;
	logic signed [42:0] acc_q, prod_q;
	logic signed [45:0] p10_q;
	logic signed [24:0] op_a;
	logic signed [17:0] op_b;
	logic signed [42:0] prod;
	logic signed [42:0] sum;
	logic [16:0]        wgt_old;
	logic [45:0]        mag;
	logic [21:0]        t;
	logic               neg;

	assign wgt_old = 17'h10000 - {1'b0, damping};

	always_comb begin
		op_a = '0;
		op_b = '0;
		priority if (cmd.mul_new) begin
			op_a = {{9{rate[15]}}, rate};
			op_b = {2'b00, damping};
		end else if (cmd.mul_old) begin
			op_a = {avg_q[23], avg_q};
			op_b = {1'b0, wgt_old};
		end else if (cmd.gain) begin
			op_a = {avg_q[23], avg_q};
			op_b = {2'b00, gain};
		end
	end

	assign prod = op_a * op_b;
	// floor of the weighted sum over 2^16 is an arithmetic shift
	assign sum  = (acc_q <<< 8) + prod_q;

	always_ff @(posedge clk) begin
		if (cmd.mul_new) acc_q <= prod;
		if (cmd.mul_old || cmd.gain) prod_q <= prod;
		if (cmd.scale) p10_q <= (46'(prod_q) <<< 3) + (46'(prod_q) <<< 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q <= '0;
		end else if (cmd.sum) begin
			avg_q <= sum[39:16];
		end
	end

	// truncate toward zero, apply the axis sign, clamp to eight bits
	assign mag = p10_q[45] ? 46'(-p10_q) : 46'(p10_q);
	assign t   = mag[45:24];
	assign neg = p10_q[45] ^ negate;

	always_comb begin
		if (!neg) begin
			move = (t > 22'd127) ? 8'sd127 : $signed(t[7:0]);
		end else begin
			move = (t >= 22'd128) ? -8'sd128 : $signed(8'(~t[7:0] + 8'd1));
		end
	end

endmodule

[sv/pgp_datapath.sv]
// Datapath: registers, item capture, two motion lanes, puff timing, output register.
// Depends on pgp_pkg and pgp_lane.
module pgp_datapath import pgp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  pgp_cmd_t    cmd,
	input  pgp_in_t     in_item,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        out_stall,
	output logic        out_valid,
	output pgp_out_t    out_item
);

	logic [15:0]         damping_q, gain_q, gap_q, hold_q;
	logic [ADC_BITS-1:0] limit_q;
	pgp_in_t             in_q;

	logic [31:0] puff_start_q, last_release_q;
	logic [1:0]  count_q;
	logic        puffing_q, hold_done_q;
	logic [1:0]  click_q;
	logic        home_q;
	logic        out_valid_q;
	pgp_out_t    out_q;

	logic signed [7:0] move_x, move_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			damping_q <= DAMPING_RESET;
			gain_q    <= GAIN_RESET;
			limit_q   <= PRESSURE_RESET;
			gap_q     <= GAP_RESET;
			hold_q    <= HOLD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DAMPING:  damping_q <= cfg_data;
				REG_GAIN:     gain_q    <= cfg_data;
				REG_PRESSURE: limit_q   <= cfg_data[ADC_BITS-1:0];
				REG_GAP:      gap_q     <= cfg_data;
				REG_HOLD:     hold_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) in_q <= in_item;
	end

	pgp_lane u_lane_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rate    (in_q.rate_horizontal),
		.damping (damping_q),
		.gain    (gain_q),
		.negate  (1'b1),
		.move    (move_x)
	);

	pgp_lane u_lane_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rate    (in_q.rate_vertical),
		.damping (damping_q),
		.gain    (gain_q),
		.negate  (1'b0),
		.move    (move_y)
	);

	// puff timing
	logic        now_puff, rise, fall, held, short_puff, counted, fire_home, fire_click;
	logic [31:0] dur, gap_time;
	logic [1:0]  count_n;

	assign now_puff   = in_q.pressure > limit_q;
	assign rise       = now_puff && !puffing_q;
	assign fall       = !now_puff && puffing_q;
	assign held       = now_puff && puffing_q;
	assign dur        = in_q.now_ms - puff_start_q;
	assign short_puff = dur < {16'd0, hold_q};
	assign counted    = fall && short_puff;
	assign fire_home  = held && !short_puff && !hold_done_q;
	assign gap_time   = counted ? 32'd0 : (in_q.now_ms - last_release_q);

	always_comb begin
		count_n = count_q;
		if (counted && count_q != 2'd3) count_n = count_q + 2'd1;
		else if (fire_home) count_n = 2'd0;
	end

	assign fire_click = !now_puff && (count_n != 2'd0) && (gap_time > {16'd0, gap_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			puff_start_q   <= '0;
			last_release_q <= '0;
			count_q        <= '0;
			puffing_q      <= 1'b0;
			hold_done_q    <= 1'b0;
			click_q        <= CLICK_NONE;
			home_q         <= 1'b0;
		end else if (cmd.gain) begin
			puffing_q <= now_puff;
			if (rise) begin
				puff_start_q <= in_q.now_ms;
				hold_done_q  <= 1'b0;
			end else if (fire_home) begin
				hold_done_q <= 1'b1;
			end
			if (counted) last_release_q <= in_q.now_ms;
			count_q <= fire_click ? 2'd0 : count_n;
			click_q <= !fire_click ? CLICK_NONE :
			           (count_n == 2'd1) ? CLICK_LEFT : CLICK_RIGHT;
			home_q  <= fire_home;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_q.move_x       <= move_x;
			out_q.move_y       <= move_y;
			out_q.click        <= click_q;
			out_q.home_request <= home_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

[sv/puff_gesture_pointer.sv]
// Top level of the breath-and-tilt pointer controller.
// Depends on pgp_pkg, pgp_ctrl, pgp_datapath (and pgp_lane below it).

// One sample in, one result out. Each sample carries two gyro rates, a pressure
// reading and a millisecond timestamp; the result carries a saturated pointer step
// per axis, a click code (none, left, right) and a one-tick home request. An item's
// result lands in the output register after five sequencer steps on one multiplier
// per axis (new sample weight, old average weight, sum, gain, scale by ten) and then
// a load step. The next item is taken in the cycle after the load, so the block
// takes no new sample while one is in work; a result left waiting under out_stall
// holds the load step and with it the next acceptance. The user must write registers
// through cfg_we/cfg_index/cfg_data only while the block is idle; the block itself
// does not enforce this. An unknown index is ignored. Timing uses modulo 2^32
// differences of now_ms.
module puff_gesture_pointer import pgp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  pgp_in_t     in_item,
	output logic        out_valid,
	input  logic        out_stall,
	output pgp_out_t    out_item,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	pgp_cmd_t cmd;

	pgp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.cmd       (cmd)
	);

	pgp_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_item   (in_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_item  (out_item)
	);

	// never overwrite a result that is still waiting
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!out_valid || !out_stall))
		else $error("result loaded over a waiting result");

	// an accepted item keeps the input side closed on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again while an item is in work");

	// a load shows up as a valid result
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> out_valid)
		else $error("loaded result not presented");

	// a click needs a released puff, homing a held one
	a_click_home_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !((out_item.click != CLICK_NONE) && out_item.home_request))
		else $error("click and home request in the same result");

endmodule

[tb/sv/pointer_check.sv]
// Checker for the breath-and-tilt pointer controller: predicts each report from the
// accepted samples and register writes, then compares the reports the block delivers.
// Depends on pgp_pkg.
module pointer_check import pgp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  pgp_in_t     in_item,
	input  logic        out_valid,
	input  logic        out_stall,
	input  pgp_out_t    out_item,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatches,
	output int          reports_waiting,
	output int          reports_seen,
	output int          clicks_seen,
	output int          homes_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [15:0]         damping;
	logic [15:0]         gain;
	logic [ADC_BITS-1:0] limit;
	logic [15:0]         gap_ms;
	logic [15:0]         hold_ms;

	logic signed [31:0] avg_x, avg_y;
	logic [31:0]        puff_start, last_release;
	logic [1:0]         short_count;
	logic               puffing, hold_done;

	pgp_out_t reports_due[$];

	// new average = floor((d * (r << 8) + (65536 - d) * avg) / 2^16)
	function automatic logic signed [31:0] smooth(logic signed [31:0] avg,
			logic signed [15:0] rate);
		longint w_new, w_old, acc;
		w_new = longint'(damping);
		w_old = 65536 - w_new;
		acc = w_new * (longint'(rate) * 256) + w_old * longint'(avg);
		return 32'(acc >>> 16);
	endfunction

	// truncate avg * gain * 10 / 2^24 toward zero, negate on request, clamp to 8 bits
	function automatic logic signed [7:0] pointer_step(logic signed [31:0] avg, logic negate);
		longint prod, mag, v;
		prod = longint'(avg) * longint'(gain) * 10;
		mag = (prod < 0) ? -prod : prod;
		v = mag >>> 24;
		if (prod < 0) v = -v;
		if (negate) v = -v;
		if (v > 127) v = 127;
		else if (v < -128) v = -128;
		return 8'(v);
	endfunction

	task automatic predict_report(input pgp_in_t s);
		pgp_out_t    r;
		logic [31:0] held, quiet;
		logic        puff_now;
		r = '0;
		r.click = CLICK_NONE;
		avg_x = smooth(avg_x, s.rate_horizontal);
		avg_y = smooth(avg_y, s.rate_vertical);
		r.move_x = pointer_step(avg_x, 1'b1);
		r.move_y = pointer_step(avg_y, 1'b0);
		puff_now = s.pressure > limit;
		held = s.now_ms - puff_start;
		if (puff_now && !puffing) begin
			puffing = 1'b1;
			puff_start = s.now_ms;
			hold_done = 1'b0;
		end else if (!puff_now && puffing) begin
			puffing = 1'b0;
			// a release at or past the hold time is not a short puff
			if (held < {16'd0, hold_ms}) begin
				if (short_count != 2'd3) short_count++;
				last_release = s.now_ms;
			end
		end else if (puff_now && puffing && held >= {16'd0, hold_ms} && !hold_done) begin
			r.home_request = 1'b1;
			hold_done = 1'b1;
			short_count = '0;
		end
		quiet = s.now_ms - last_release;
		if (!puffing && short_count != 0 && quiet > {16'd0, gap_ms}) begin
			r.click = (short_count == 2'd1) ? CLICK_LEFT : CLICK_RIGHT;
			short_count = '0;
		end
		reports_due.push_back(r);
	endtask

	task automatic flag(input string field, input logic signed [31:0] want,
			input logic signed [31:0] got);
		mismatches++;
		$error("%s: expected %0d, got %0d", field, want, got);
	endtask

	task automatic compare_report(input pgp_out_t got);
		pgp_out_t want;
		if (reports_due.size() == 0) begin
			mismatches++;
			$error("report delivered with none outstanding: %p", got);
			return;
		end
		want = reports_due.pop_front();
		reports_seen++;
		if (want.click != CLICK_NONE) clicks_seen++;
		if (want.home_request) homes_seen++;
		if (got.move_x !== want.move_x) flag("move_x", want.move_x, got.move_x);
		if (got.move_y !== want.move_y) flag("move_y", want.move_y, got.move_y);
		if (got.click !== want.click) flag("click", want.click, got.click);
		if (got.home_request !== want.home_request)
			flag("home_request", want.home_request, got.home_request);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			damping = DAMPING_RESET;
			gain = GAIN_RESET;
			limit = PRESSURE_RESET;
			gap_ms = GAP_RESET;
			hold_ms = HOLD_RESET;
			avg_x = '0;
			avg_y = '0;
			puff_start = '0;
			last_release = '0;
			short_count = '0;
			puffing = 1'b0;
			hold_done = 1'b0;
			reports_due.delete();
			mismatches = 0;
			reports_waiting = 0;
			reports_seen = 0;
			clicks_seen = 0;
			homes_seen = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DAMPING:  damping = cfg_data;
					REG_GAIN:     gain = cfg_data;
					REG_PRESSURE: limit = cfg_data[ADC_BITS-1:0];
					REG_GAP:      gap_ms = cfg_data;
					REG_HOLD:     hold_ms = cfg_data;
					default:      ;
				endcase
			end
			if (in_valid && !in_stall) predict_report(in_item);
			if (out_valid && !out_stall) compare_report(out_item);
			reports_waiting = reports_due.size();
		end
	end

endmodule

[tb/sv/testbench.sv]
// Top of the pointer controller testbench: clock, reset, sample and register stimulus,
// random idling on both channels, watchdog and verdict.
// Depends on pgp_pkg, puff_gesture_pointer and pointer_check.
module testbench;
	import pgp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 190;
	localparam int SETTLE_CYCLES  = 16;
	localparam int WATCHDOG_LIMIT = 2000;

	localparam logic signed [15:0]   RATE_PEAK   = 16'sh7FFF;
	localparam logic signed [15:0]   RATE_TROUGH = 16'sh8000;
	localparam logic [ADC_BITS-1:0]  FULL_SCALE  = '1;
	localparam logic [ADC_BITS-1:0]  ZERO_LEVEL  = '0;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	pgp_in_t     in_item = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	pgp_out_t    out_item;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	int mismatches, reports_waiting, reports_seen, clicks_seen, homes_seen;

	// stimulus-side copies of the registers that shape the gestures
	logic [ADC_BITS-1:0] lim = PRESSURE_RESET;
	logic [15:0]         gap_ms = GAP_RESET;
	logic [15:0]         hold_ms = HOLD_RESET;

	logic [31:0] clock_ms = '0;
	int          items_sent = 0;
	int          send_idle_pct = 0;
	int          take_stall_pct = 0;
	int          quiet_cycles = 0;

	puff_gesture_pointer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pointer_check check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_item         (in_item),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_item        (out_item),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatches      (mismatches),
		.reports_waiting (reports_waiting),
		.reports_seen    (reports_seen),
		.clicks_seen     (clicks_seen),
		.homes_seen      (homes_seen)
	);

	always #4 clk = ~clk;

	// stall the result side at random, at the current phase's rate
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < take_stall_pct);
	end

	// end the run if neither channel moves an item for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// mix of full-range, moderate, extreme and near-zero rates
	function automatic logic signed [15:0] rand_rate();
		case ($urandom_range(3))
			0:       return 16'($urandom());
			1:       return 16'($urandom_range(1024) - 512);
			2:       return $urandom_range(1) ? RATE_PEAK : RATE_TROUGH;
			default: return 16'($urandom_range(32) - 16);
		endcase
	endfunction

	// pressure above the limit; at full-scale limit no puff is possible
	function automatic logic [ADC_BITS-1:0] puff_level();
		if (lim == FULL_SCALE) return FULL_SCALE;
		return ADC_BITS'($urandom_range(FULL_SCALE, lim + 1));
	endfunction

	function automatic logic [ADC_BITS-1:0] rest_level();
		return ADC_BITS'($urandom_range(lim, 0));
	endfunction

	// offer one item on the sample channel, idling first at the phase's rate,
	// and hold it until the block takes it
	task automatic offer(input pgp_in_t s);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic tick_at(input logic signed [15:0] rx, input logic signed [15:0] ry,
			input logic [ADC_BITS-1:0] level, input logic [31:0] t);
		pgp_in_t s;
		s.rate_horizontal = rx;
		s.rate_vertical = ry;
		s.pressure = level;
		s.now_ms = t;
		clock_ms = t;
		offer(s);
	endtask

	// advance the time stamp by dt and send a sample with random rates
	task automatic send_tick(input logic [ADC_BITS-1:0] level, input logic [31:0] dt);
		tick_at(rand_rate(), rand_rate(), level, clock_ms + dt);
	endtask

	// a puff released before the hold time, with up to two held samples inside it
	task automatic short_puff(input logic [31:0] lead);
		logic [31:0] rest, dt_part;
		if (hold_ms == 0)
			rest = '0;
		else if ($urandom_range(3) == 0)
			rest = hold_ms - 1;
		else
			rest = $urandom_range(hold_ms - 1);
		send_tick(puff_level(), lead);
		repeat ($urandom_range(2)) begin
			dt_part = $urandom_range(rest);
			send_tick(puff_level(), dt_part);
			rest -= dt_part;
		end
		send_tick(rest_level(), rest);
	endtask

	// a puff held past the hold time: sample just short of it, then at or past it
	task automatic long_puff(input logic [31:0] lead);
		send_tick(puff_level(), lead);
		if (hold_ms != 0) send_tick(puff_level(), hold_ms - 1);
		send_tick(puff_level(), $urandom_range(200) + (hold_ms != 0));
		send_tick(puff_level(), $urandom_range(200));
		send_tick(rest_level(), $urandom_range(400));
	endtask

	task automatic random_gesture();
		int kind;
		kind = $urandom_range(99);
		if (kind < 15) begin
			// noise: any pressure, loose timing, now and then a jump anywhere in time
			repeat ($urandom_range(4, 1)) begin
				if ($urandom_range(19) == 0) clock_ms = $urandom();
				send_tick(ADC_BITS'($urandom()), $urandom_range(3000));
			end
		end else begin
			// a burst of puffs inside the window, then a rest sample at or past the window's end
			repeat ($urandom_range(4, 1)) begin
				if ($urandom_range(4) == 0)
					long_puff($urandom_range(gap_ms));
				else
					short_puff($urandom_range(gap_ms));
			end
			case ($urandom_range(3))
				0:       send_tick(rest_level(), 32'(gap_ms));
				1:       send_tick(rest_level(), gap_ms + 1);
				default: send_tick(rest_level(), gap_ms + $urandom_range(200, 1));
			endcase
			if ($urandom_range(1)) send_tick(rest_level(), $urandom_range(300));
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_PRESSURE: lim = value[ADC_BITS-1:0];
			REG_GAP:      gap_ms = value;
			REG_HOLD:     hold_ms = value;
			default:      ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(input logic [15:0] damping, input logic [15:0] gain,
			input logic [15:0] limit, input logic [15:0] gap, input logic [15:0] hold);
		write_reg(REG_DAMPING, damping);
		write_reg(REG_GAIN, gain);
		write_reg(REG_PRESSURE, limit);
		write_reg(REG_GAP, gap);
		write_reg(REG_HOLD, hold);
		// an index past the last register must leave everything alone
		write_reg(3'($urandom_range(7, REG_HOLD + 1)), 16'($urandom()));
	endtask

	// drop valid, wait for every report to come back, then let the block go quiet
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (reports_waiting != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		int phase_end;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part under the reset register values: extreme rates, the limit
		// itself versus one above it, click decisions at the window edge, count
		// saturation, a long hold across the time wrap, a release exactly at hold
		tick_at(RATE_PEAK, RATE_PEAK, ZERO_LEVEL, 0);
		tick_at(RATE_PEAK, RATE_TROUGH, PRESSURE_RESET, 10);
		tick_at(RATE_TROUGH, RATE_TROUGH, ZERO_LEVEL, 20);
		tick_at(rand_rate(), rand_rate(), ADC_BITS'(PRESSURE_RESET + 1), 40);
		tick_at(rand_rate(), rand_rate(), ZERO_LEVEL, 140);
		tick_at(rand_rate(), rand_rate(), ZERO_LEVEL, 540);
		tick_at(rand_rate(), rand_rate(), ZERO_LEVEL, 541);
		tick_at(rand_rate(), rand_rate(), FULL_SCALE, 1000);
		tick_at(rand_rate(), rand_rate(), ZERO_LEVEL, 1100);
		tick_at(rand_rate(), rand_rate(), FULL_SCALE, 1200);
		tick_at(rand_rate(), rand_rate(), ZERO_LEVEL, 1300);
		tick_at(rand_rate(), rand_rate(), ZERO_LEVEL, 1701);
		for (int i = 0; i < 4; i++) begin
			tick_at(rand_rate(), rand_rate(), FULL_SCALE, 2000 + 20 * i);
			tick_at(rand_rate(), rand_rate(), ZERO_LEVEL, 2010 + 20 * i);
		end
		tick_at(rand_rate(), rand_rate(), ZERO_LEVEL, 2500);
		tick_at(rand_rate(), rand_rate(), FULL_SCALE, 32'hFFFF_FC00);
		tick_at(rand_rate(), rand_rate(), FULL_SCALE, 32'hFFFF_FC00 + 1199);
		tick_at(rand_rate(), rand_rate(), FULL_SCALE, 32'hFFFF_FC00 + 1200);
		tick_at(rand_rate(), rand_rate(), ZERO_LEVEL, 32'hFFFF_FC00 + 1300);
		tick_at(rand_rate(), rand_rate(), FULL_SCALE, 5000);
		tick_at(rand_rate(), rand_rate(), ZERO_LEVEL, 6200);

		// random part: one register setting and one idling pattern per phase
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph)
				0:       ; // keep the reset values
				1:       write_all(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
				2:       write_all(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
				4:       write_all(16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001);
				6:       write_all(16'h8000, 16'h0100, 16'h0200, 16'd50, 16'd300);
				default: write_all(16'($urandom()), 16'($urandom()), 16'($urandom()),
						16'($urandom_range(2000)), 16'($urandom_range(3000)));
			endcase
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					take_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 55;
					take_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					take_stall_pct = 55;
				end
				default: begin
					send_idle_pct = 32;
					take_stall_pct = 32;
				end
			endcase
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) random_gesture();
		end

		settle();
		$display("Sent %0d samples over %0d register settings and four idling patterns;",
				items_sent, PHASES);
		$display("checked %0d reports, %0d carrying a click and %0d a home request.",
				reports_seen, clicks_seen, homes_seen);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
